FILE: rtl/core/nfa_bitset_recognizer_top_assert.svh
// assertion macros used by the recognizer datapath
`ifndef NFA_BITSET_RECOGNIZER_TOP_ASSERT_SVH
`define NFA_BITSET_RECOGNIZER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NBR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define NBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/nbr_pkg.sv
// types and constants shared by the recognizer modules
`timescale 1ns / 1ps

package nbr_pkg;

  localparam int CMD_W    = 2;
  localparam int LETTER_W = 2;
  localparam int STATE_W  = 4;
  localparam int SET_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_START_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_MASK = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_SYMBOL = 2'd1,
    CMD_EOW    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_STEP,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic add_wr;
    logic step_issue;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic step_last;
    logic add_ok;
    logic out_free;
  } ctrl_sts_t;

endpackage

FILE: rtl/core/nbr_ram.sv
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps

module nbr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/nbr_ctrl.sv
// sequencer for clearing, transition updates and symbol steps
`timescale 1ns / 1ps

module nbr_ctrl
  import nbr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    command_i,
  input  ctrl_sts_t           sts_i,
  output ctrl_cmd_t           cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (cmd_e'(command_i))
            CMD_ADD:    state_d = ST_ADD_RD;
            CMD_SYMBOL: state_d = ST_STEP;
            CMD_EOW:    state_d = ST_EMIT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD: begin
        state_d = sts_i.add_ok ? ST_ADD_WR : ST_IDLE;
      end
      ST_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_STEP: begin
        cmd_o.step_issue = 1'b1;
        if (sts_i.step_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/nbr_dp.sv
// transition store, active set, accumulator and result register
`timescale 1ns / 1ps
`include "nfa_bitset_recognizer_top_assert.svh"

module nbr_dp
  import nbr_pkg::*;
#(
  parameter int NUM_STATES  = 16,
  parameter int NUM_LETTERS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [LETTER_W-1:0]  letter_i,
  input  logic [STATE_W-1:0]   from_state_i,
  input  logic [STATE_W-1:0]   to_state_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [SET_W-1:0]     active_set_o,
  output logic                 accepted_o,
  output logic                 word_done_o,
  input  ctrl_cmd_t            cmd_i,
  output ctrl_sts_t            sts_o
);

  localparam int ROWS = NUM_STATES * NUM_LETTERS;
  localparam int RAW  = $clog2(ROWS);
  localparam int SW   = $clog2(NUM_STATES);
  localparam int CW   = (NUM_STATES < SET_W) ? NUM_STATES : SET_W;

  logic [CFG_W-1:0]      start_mask_q, final_mask_q;
  logic [NUM_STATES-1:0] start_ext, final_ext;
  logic [NUM_STATES-1:0] cur_q, cur_d;
  logic                  in_word_q, in_word_d;
  logic [NUM_STATES-1:0] acc_q, acc_d;
  logic [SW-1:0]         idx_q, idx_d;
  logic [SW-1:0]         rd_idx_q;
  logic                  rd_pend_q;
  logic [RAW-1:0]        clr_addr_q;
  cmd_e                  cmd_q;
  logic [LETTER_W-1:0]   letter_q;
  logic [STATE_W-1:0]    from_q, to_q;
  logic                  out_valid_q, out_valid_d;
  logic [SET_W-1:0]      out_set_q;
  logic                  out_acc_q, out_done_q;

  logic                  letter_ok, add_ok;
  logic [NUM_STATES-1:0] to_onehot, rdata, step_set, emit_set;
  logic [RAW-1:0]        add_addr, step_addr, raddr, waddr;
  logic [NUM_STATES-1:0] wdata;
  logic                  we;
  logic [SET_W-1:0]      emit_set16;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_mask_q <= CFG_W'(1);
      final_mask_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_START_MASK: start_mask_q <= cfg_data_i;
        REG_FINAL_MASK: final_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    start_ext = '0;
    final_ext = '0;
    start_ext[CW-1:0] = start_mask_q[CW-1:0];
    final_ext[CW-1:0] = final_mask_q[CW-1:0];
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q    <= cmd_e'(command_i);
      letter_q <= letter_i;
      from_q   <= from_state_i;
      to_q     <= to_state_i;
    end
  end

  assign letter_ok = int'(letter_q) < NUM_LETTERS;
  assign add_ok    = letter_ok && (int'(from_q) < NUM_STATES) && (int'(to_q) < NUM_STATES);

  always_comb begin
    for (int i = 0; i < NUM_STATES; i++) begin
      to_onehot[i] = (int'(to_q) == i);
    end
  end

  assign add_addr  = RAW'(int'(from_q) * NUM_LETTERS + int'(letter_q));
  assign step_addr = RAW'(int'(idx_q) * NUM_LETTERS + int'(letter_q));
  assign raddr     = cmd_i.step_issue ? step_addr : add_addr;
  assign we        = cmd_i.clear_en || cmd_i.add_wr;
  assign waddr     = cmd_i.clear_en ? clr_addr_q : add_addr;
  assign wdata     = cmd_i.clear_en ? '0 : (rdata | to_onehot);

  nbr_ram #(
    .WIDTH (NUM_STATES),
    .DEPTH (ROWS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_addr_q <= clr_addr_q + RAW'(1);
    end
  end

  // symbol step and word state
  assign step_set   = letter_ok ? acc_q : '0;
  assign emit_set   = (cmd_q == CMD_SYMBOL) ? step_set : cur_q;

  always_comb begin
    emit_set16 = '0;
    emit_set16[CW-1:0] = emit_set[CW-1:0];
  end

  always_comb begin
    cur_d     = cur_q;
    in_word_d = in_word_q;
    acc_d     = acc_q;
    idx_d     = idx_q;
    if (cmd_i.accept) begin
      acc_d = '0;
      idx_d = '0;
      if (!in_word_q) begin
        cur_d = start_ext;
      end
    end
    if (cmd_i.step_issue) begin
      idx_d = idx_q + SW'(1);
    end
    if (rd_pend_q && cur_q[rd_idx_q]) begin
      acc_d = acc_q | rdata;
    end
    if (cmd_i.emit) begin
      if (cmd_q == CMD_SYMBOL) begin
        cur_d     = step_set;
        in_word_d = 1'b1;
      end else begin
        cur_d     = '0;
        in_word_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      in_word_q <= 1'b0;
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      cur_q     <= cur_d;
      in_word_q <= in_word_d;
      idx_q     <= idx_d;
      rd_pend_q <= cmd_i.step_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    rd_idx_q <= idx_q;
  end

  // result register
  assign out_valid_d = cmd_i.emit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_set_q  <= emit_set16;
      out_acc_q  <= |(emit_set & final_ext);
      out_done_q <= (cmd_q == CMD_EOW);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign active_set_o = out_set_q;
  assign accepted_o   = out_acc_q;
  assign word_done_o  = out_done_q;

  assign sts_o.clear_last = (clr_addr_q == RAW'(ROWS - 1));
  assign sts_o.step_last  = (idx_q == SW'(NUM_STATES - 1));
  assign sts_o.add_ok     = add_ok;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  `NBR_ASSERT_IMPLY(a_no_overwrite, clk_i, rst_ni, cmd_i.emit,
                    !out_valid_q || out_ready_i, "result overwritten before transfer")
  `NBR_ASSERT_NEXT(a_word_closed, clk_i, rst_ni, cmd_i.emit && (cmd_q == CMD_EOW),
                   !in_word_q && (cur_q == '0), "word not closed after end of word")
  `NBR_ASSERT_IMPLY(a_add_in_range, clk_i, rst_ni, cmd_i.add_wr, add_ok,
                    "rejected transition written")

endmodule

FILE: rtl/core/nfa_bitset_recognizer_top.sv
// bit-parallel nfa recognizer: sequencer, datapath and transition store
//
// input channel (in_valid_i/in_ready_o) carries one command per transfer:
//   add transition ORs to_state into the row of (from_state, letter), no result
//   feed symbol steps the active set and returns it with accepted
//   end of word returns the set with accepted and word_done, then closes the word
// output channel (out_valid_o/out_ready_i) has a result register; a new item is
// taken while a result still waits, and the block only stalls when the next
// result is ready and the register is still held by the receiver
// steps per command: add transition reads the row, then writes it back (no write
//   when rejected); an unused command returns to idle; feed symbol reads one
//   transition row per state from the single read port of the store
// to out_valid_o: end of word goes straight to emit, feed symbol via step and drain
// reset: after rst_ni releases, the transition store is cleared one row a cycle
//   with in_ready_o low; config writes are taken throughout. start mask resets
//   to state 0, final mask to none
// config: cfg_we_i writes cfg_data_i to register cfg_index_i at once
`timescale 1ns / 1ps

module nfa_bitset_recognizer_top
  import nbr_pkg::*;
#(
  parameter int NUM_STATES  = 16,
  parameter int NUM_LETTERS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [LETTER_W-1:0]  letter_i,
  input  logic [STATE_W-1:0]   from_state_i,
  input  logic [STATE_W-1:0]   to_state_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SET_W-1:0]     active_set_o,
  output logic                 accepted_o,
  output logic                 word_done_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;

  nbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd)
  );

  nbr_dp #(
    .NUM_STATES  (NUM_STATES),
    .NUM_LETTERS (NUM_LETTERS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (command_i),
    .letter_i     (letter_i),
    .from_state_i (from_state_i),
    .to_state_i   (to_state_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .active_set_o (active_set_o),
    .accepted_o   (accepted_o),
    .word_done_o  (word_done_o),
    .cmd_i        (ctrl_cmd),
    .sts_o        (ctrl_sts)
  );

endmodule
